// File: src/fsgs_pkg.sv
// ----------------------------------------------------------------------------
// fsgs_pkg
// Shared types, grid geometry and cell and command codes for the
// falling-sand grid block.
// ----------------------------------------------------------------------------
package fsgs_pkg;

  // Grid geometry; row 0 is the top row.
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int XC_W        = $clog2(GRID_WIDTH);
  localparam int YC_W        = $clog2(GRID_HEIGHT);

  // Cell contents.
  localparam logic [1:0] CELL_EMPTY  = 2'd0;
  localparam logic [1:0] CELL_WALL   = 2'd1;
  localparam logic [1:0] CELL_SAND   = 2'd2;
  localparam logic [1:0] CELL_STATIC = 2'd3;

  // Operation codes of an input word.
  localparam logic [1:0] OP_PLACE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Command kinds after classification.
  localparam logic [1:0] CMD_PLACE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       place_kind;
    logic       fall_side;
  } in_word_t;

  typedef struct packed {
    logic [1:0] cell_value;
    logic       placed;
  } out_word_t;

  // Classified command passed from the front end to the engine.
  typedef struct packed {
    logic [1:0]        kind;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        put_val;
    logic              side;
  } cmd_t;

  // Handshake between the command queue and the engine.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// File: src/falling_sand_grid_step.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_step
// Falling-sand grid: place, read and advance a 64 x 64 grid of 2-bit cells.
// ----------------------------------------------------------------------------
// After reset the grid memory is cleared one cell per cycle, during which
// in_ready stays low. Every input word yields exactly one result word. A
// front end classifies words into a two-entry queue, so new words are taken
// while the engine works or a result waits. A place or read of an on-grid
// cell passes through the operate state, which loads the result; an off-grid
// place or read and an unused operation load it in the idle state. A tick
// sweeps rows from the second-lowest up to the top, left to right, through
// the single read and write port of the grid memory. The bottom row is
// skipped because nothing below it is free. Each cell is examined in the
// source state; a grain then checks the cell below and, if that is taken,
// the diagonal one on its fall side, moves into the first empty one and
// then vacates its source. Cells outside the grid count as walls.
// ----------------------------------------------------------------------------
module falling_sand_grid_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fsgs_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output fsgs_pkg::out_word_t out_word
);
  import fsgs_pkg::*;

  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;
  logic      clearing;
  q_status_t q_status;

  // Front end: accept and classify.
  fsgs_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_full   (q_status.full),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Command queue.
  fsgs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // Engine with the grid memory.
  fsgs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_cmd     (head_cmd),
    .q_pop     (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// File: src/fsgs_front.sv
// ----------------------------------------------------------------------------
// fsgs_front
// Accepts input words, checks coordinates against the grid, forms the
// linear cell address and pushes a classified command into the queue.
// ----------------------------------------------------------------------------
module fsgs_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  fsgs_pkg::in_word_t in_word,
  input  logic               q_full,
  input  logic               clearing,
  output logic               push,
  output fsgs_pkg::cmd_t     cmd
);
  import fsgs_pkg::*;

  // Hold off while the queue is full or the grid is still being cleared.
  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  // Classify the word.
  always_comb begin
    cmd          = '0;
    cmd.in_range = (32'(in_word.cell_x) < GRID_WIDTH) &&
                   (32'(in_word.cell_y) < GRID_HEIGHT);
    cmd.addr     = ADDR_W'(32'(in_word.cell_y) * GRID_WIDTH + 32'(in_word.cell_x));
    cmd.put_val  = in_word.place_kind ? CELL_SAND : CELL_STATIC;
    cmd.side     = in_word.fall_side;
    unique case (in_word.operation)
      OP_PLACE: cmd.kind = CMD_PLACE;
      OP_TICK:  cmd.kind = CMD_TICK;
      OP_READ:  cmd.kind = CMD_READ;
      OP_NONE:  cmd.kind = CMD_NONE;
      default:  cmd.kind = CMD_NONE;
    endcase
  end

endmodule

// File: src/fsgs_queue.sv
// ----------------------------------------------------------------------------
// fsgs_queue
// Two-entry command queue between the front end and the engine.
// ----------------------------------------------------------------------------
module fsgs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fsgs_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output fsgs_pkg::cmd_t      head_cmd,
  output fsgs_pkg::q_status_t status
);
  import fsgs_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head_cmd     = slot_r[rd_ptr_r];
  assign status.valid = (count_r != 2'd0);
  assign status.full  = (count_r == 2'd2);

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = 2'(count_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/fsgs_engine.sv
// ----------------------------------------------------------------------------
// fsgs_engine
// Owns the grid memory. Clears it after reset, then carries out queued
// commands one at a time and drives the result register.
// ----------------------------------------------------------------------------
module fsgs_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  fsgs_pkg::q_status_t q_status,
  input  fsgs_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_ready,
  output fsgs_pkg::out_word_t out_word
);
  import fsgs_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_OPER  = 3'd2;
  localparam logic [2:0] ST_SRC   = 3'd3;
  localparam logic [2:0] ST_DOWN  = 3'd4;
  localparam logic [2:0] ST_DIAG  = 3'd5;
  localparam logic [2:0] ST_MOVE  = 3'd6;

  localparam logic [ADDR_W-1:0] START_ADDR = ADDR_W'((GRID_HEIGHT - 2) * GRID_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(GRID_WIDTH);
  localparam logic [ADDR_W-1:0] ROW_BACK   = ADDR_W'(2 * GRID_WIDTH - 1);
  localparam logic [XC_W-1:0]   X_LAST     = XC_W'(GRID_WIDTH - 1);
  localparam logic [YC_W-1:0]   Y_START    = YC_W'(GRID_HEIGHT - 2);

  logic [1:0]        mem [CELLS];
  logic [1:0]        rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [1:0]        mem_wd;

  logic [2:0]        st_r, st_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [XC_W-1:0]   x_r, x_nxt;
  logic [YC_W-1:0]   y_r, y_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              out_load;
  logic              advance;
  logic              last_cell;
  logic              diag_ok;
  logic [ADDR_W-1:0] below_addr, diag_addr, next_addr;

  assign clearing  = (st_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Neighbor addresses of the grain under inspection.
  always_comb begin
    below_addr = ADDR_W'(src_r + ROW_STEP);
    diag_addr  = cmd_r.side ? ADDR_W'(below_addr + ADDR_W'(1))
                            : ADDR_W'(below_addr - ADDR_W'(1));
    diag_ok    = cmd_r.side ? (x_r != X_LAST) : (x_r != '0);
    last_cell  = (y_r == '0) && (x_r == X_LAST);
    next_addr  = (x_r == X_LAST) ? ADDR_W'(src_r - ROW_BACK)
                                 : ADDR_W'(src_r + ADDR_W'(1));
  end

  // Sequencer.
  always_comb begin
    st_nxt       = st_r;
    src_nxt      = src_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    cmd_nxt      = cmd_r;
    mem_we       = 1'b0;
    mem_wa       = src_r;
    mem_wd       = CELL_EMPTY;
    mem_ra       = src_r;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    out_word_nxt = '0;
    advance      = 1'b0;

    unique case (st_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        src_nxt = ADDR_W'(src_r + ADDR_W'(1));
        if (src_r == LAST_ADDR) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // The result slot is free or draining when a command is taken, so
        // nothing else can fill it before this command finishes.
        if (q_status.valid && (!out_valid_r || out_ready)) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          unique case (q_cmd.kind)
            CMD_TICK: begin
              src_nxt = START_ADDR;
              x_nxt   = '0;
              y_nxt   = Y_START;
              mem_ra  = START_ADDR;
              st_nxt  = ST_SRC;
            end
            CMD_PLACE, CMD_READ: begin
              if (q_cmd.in_range) begin
                mem_ra = q_cmd.addr;
                st_nxt = ST_OPER;
              end else begin
                // Off-grid cells read as walls and never take a place.
                out_load = 1'b1;
                out_word_nxt.cell_value = (q_cmd.kind == CMD_READ) ? CELL_WALL
                                                                   : CELL_EMPTY;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_OPER: begin
        out_load = 1'b1;
        st_nxt   = ST_IDLE;
        if (cmd_r.kind == CMD_PLACE) begin
          if (rdata_r == CELL_EMPTY) begin
            mem_we              = 1'b1;
            mem_wa              = cmd_r.addr;
            mem_wd              = cmd_r.put_val;
            out_word_nxt.placed = 1'b1;
          end
        end else begin
          out_word_nxt.cell_value = rdata_r;
        end
      end
      ST_SRC: begin
        // Only sand grains do anything; other cells are stepped past.
        if (rdata_r == CELL_SAND) begin
          mem_ra = below_addr;
          st_nxt = ST_DOWN;
        end else begin
          advance = 1'b1;
        end
      end
      ST_DOWN: begin
        if (rdata_r == CELL_EMPTY) begin
          mem_we = 1'b1;
          mem_wa = below_addr;
          mem_wd = CELL_SAND;
          st_nxt = ST_MOVE;
        end else if (diag_ok) begin
          mem_ra = diag_addr;
          st_nxt = ST_DIAG;
        end else begin
          advance = 1'b1;
        end
      end
      ST_DIAG: begin
        if (rdata_r == CELL_EMPTY) begin
          mem_we = 1'b1;
          mem_wa = diag_addr;
          mem_wd = CELL_SAND;
          st_nxt = ST_MOVE;
        end else begin
          advance = 1'b1;
        end
      end
      ST_MOVE: begin
        // Vacate the source cell.
        mem_we  = 1'b1;
        advance = 1'b1;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // Step to the next cell of the sweep, or finish the tick.
    if (advance) begin
      if (last_cell) begin
        out_load = 1'b1;
        st_nxt   = ST_IDLE;
      end else begin
        src_nxt = next_addr;
        mem_ra  = next_addr;
        st_nxt  = ST_SRC;
        if (x_r == X_LAST) begin
          x_nxt = '0;
          y_nxt = YC_W'(y_r - YC_W'(1));
        end else begin
          x_nxt = XC_W'(x_r + XC_W'(1));
        end
      end
    end
  end

  // Result register.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      src_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      src_r       <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    cmd_r <= cmd_nxt;
    if (out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  // Grid memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

endmodule
